// ===== rtl/core/slid_pkg.sv =====
// slid_pkg: shared types and constants for the sorted list insert/delete block.
// Used by slid_cmp, slid_seq and sorted_list_insert_delete_top; no dependencies.
`timescale 1ns / 1ps

package slid_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int POS_W  = 4;
  localparam int MODE_W = 2;
  localparam int OUT_CNT_W = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] new_value;
    logic [POS_W-1:0]        position;
  } cmd_t;

  typedef struct packed {
    logic                    ok;
    logic [OUT_CNT_W-1:0]    count_after;
    logic signed [VAL_W-1:0] removed_value;
  } rsp_t;

endpackage

// ===== rtl/core/slid_ram.sv =====
// slid_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module slid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/slid_cmp.sv =====
// slid_cmp: shared signed compare unit used by the insert scan.
// Depends on slid_pkg.
`timescale 1ns / 1ps

module slid_cmp (
  input  logic signed [slid_pkg::VAL_W-1:0] entry,
  input  logic signed [slid_pkg::VAL_W-1:0] key,
  output logic                              ge
);

  assign ge = (entry >= key);

endmodule

// ===== rtl/core/slid_seq.sv =====
// slid_seq: sequencer for insert, delete and pop over the value RAM.
// Depends on slid_pkg and slid_cmp; drives the ports of one slid_ram.
`timescale 1ns / 1ps

module slid_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  slid_pkg::cmd_t                 cmd,
  output logic                           busy,
  output logic                           done,
  input  logic                           take,
  output slid_pkg::rsp_t                 result,
  output logic                           ram_we,
  output logic [slid_pkg::ADDR_W-1:0]    ram_waddr,
  output logic [slid_pkg::VAL_W-1:0]     ram_wdata,
  output logic [slid_pkg::ADDR_W-1:0]    ram_raddr,
  input  logic [slid_pkg::VAL_W-1:0]     ram_rdata
);

  typedef enum logic [2:0] {
    IDLE,
    INS_RD,
    INS_CMP,
    DEL_RD,
    DEL_CMP,
    DONE
  } state_t;

  state_t                          state;
  logic [slid_pkg::CNT_W-1:0]      count;
  logic [slid_pkg::ADDR_W-1:0]     slot;
  logic [slid_pkg::ADDR_W-1:0]     idx;
  logic signed [slid_pkg::VAL_W-1:0] value;
  logic signed [slid_pkg::VAL_W-1:0] removed;
  logic                            ok;
  logic                            first;
  logic                            ge;
  logic [slid_pkg::CNT_W-1:0]      idx_inc;
  logic [slid_pkg::CNT_W-1:0]      pos_ext;

  slid_cmp u_cmp (
    .entry (ram_rdata),
    .key   (value),
    .ge    (ge)
  );

  assign idx_inc = slid_pkg::CNT_W'(idx) + slid_pkg::CNT_W'(1);
  assign pos_ext = slid_pkg::CNT_W'(cmd.position);

  assign busy = (state != IDLE);
  assign done = (state == DONE);
  assign result.ok            = ok;
  assign result.count_after   = slid_pkg::OUT_CNT_W'(count);
  assign result.removed_value = removed;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = value;
    ram_raddr = idx;
    unique case (state)
      INS_RD: begin
        if (slot == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = slot - slid_pkg::ADDR_W'(1);
        end
      end
      INS_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = ge ? ram_rdata : value;
      end
      DEL_CMP: begin
        ram_we    = !first;
        ram_waddr = idx - slid_pkg::ADDR_W'(1);
        ram_wdata = ram_rdata;
      end
      IDLE, DEL_RD, DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      ok    <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            value   <= cmd.new_value;
            removed <= '0;
            ok      <= 1'b0;
            first   <= 1'b1;
            slot    <= slid_pkg::ADDR_W'(count);
            state   <= DONE;
            priority if (cmd.mode == slid_pkg::MODE_INSERT) begin
              if (count < slid_pkg::CNT_W'(slid_pkg::DEPTH)) begin
                state <= INS_RD;
              end
            end else if (cmd.mode == slid_pkg::MODE_DELETE) begin
              if (pos_ext < count) begin
                idx   <= slid_pkg::ADDR_W'(cmd.position);
                state <= DEL_RD;
              end
            end else if (cmd.mode == slid_pkg::MODE_POP) begin
              if (count != '0) begin
                idx   <= '0;
                state <= DEL_RD;
              end
            end else begin
              state <= DONE;
            end
          end
        end
        INS_RD: begin
          if (slot == '0) begin
            ok    <= 1'b1;
            count <= count + slid_pkg::CNT_W'(1);
            state <= DONE;
          end else begin
            state <= INS_CMP;
          end
        end
        INS_CMP: begin
          if (ge) begin
            slot  <= slot - slid_pkg::ADDR_W'(1);
            state <= INS_RD;
          end else begin
            ok    <= 1'b1;
            count <= count + slid_pkg::CNT_W'(1);
            state <= DONE;
          end
        end
        DEL_RD: begin
          state <= DEL_CMP;
        end
        DEL_CMP: begin
          first <= 1'b0;
          if (first) begin
            removed <= ram_rdata;
          end
          if (idx_inc < count) begin
            idx   <= idx + slid_pkg::ADDR_W'(1);
            state <= DEL_RD;
          end else begin
            ok    <= 1'b1;
            count <= count - slid_pkg::CNT_W'(1);
            state <= DONE;
          end
        end
        DONE: begin
          if (take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sorted_list_insert_delete_top.sv =====
// Sorted list of up to slid_pkg::DEPTH signed 32-bit values.
// Command channel: cmd_valid / cmd_stall / cmd (mode, new_value, position).
//   Mode insert places new_value before the first entry >= it; mode delete
//   removes the entry at position; mode pop removes the smallest entry.
// Response channel: rsp_valid / rsp_stall / rsp (ok, count_after,
//   removed_value), one response transaction per command transaction.
// One command is worked at a time; cmd_stall is high from acceptance until
// the response is loaded into the output register. Values live in a RAM
// with registered read, and one compare unit walks the list one entry at a
// time: an insert reads the entry below the free slot (state INS_RD), then
// compares it (INS_CMP) and shifts it up while it is >= the new value; a
// delete reads each entry from position on (DEL_RD) and writes it one slot
// down (DEL_CMP). A failed command goes straight to the response.
// A new command is taken while the last response still waits in the output
// register. If rsp_stall holds, a finished result waits in the sequencer
// and the command side stays stalled.
// Reset (rst, synchronous) empties the list; no RAM clearing is needed.
// Depends on slid_pkg, slid_seq, slid_cmp and slid_ram.
`timescale 1ns / 1ps

module sorted_list_insert_delete_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  slid_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output slid_pkg::rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic                           take;
  slid_pkg::rsp_t                 result;
  logic                           ram_we;
  logic [slid_pkg::ADDR_W-1:0]    ram_waddr;
  logic [slid_pkg::VAL_W-1:0]     ram_wdata;
  logic [slid_pkg::ADDR_W-1:0]    ram_raddr;
  logic [slid_pkg::VAL_W-1:0]     ram_rdata;

  assign cmd_stall = busy;
  assign take      = done && (!rsp_valid || !rsp_stall);

  slid_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd_valid),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .take      (take),
    .result    (result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  slid_ram #(
    .WIDTH (slid_pkg::VAL_W),
    .DEPTH (slid_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= result;
    end
  end

endmodule

// ===== tb/sorted_list_insert_delete_top_tb.sv =====
// Testbench for sorted_list_insert_delete_top: directed and random insert, delete and pop
// transactions checked against an in-bench model of the sorted table.
// Depends on slid_pkg and the sorted_list_insert_delete_top RTL.
`timescale 1ns / 1ps

module sorted_list_insert_delete_top_tb;

  localparam logic [slid_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_START   = 400;
  localparam int HOLD_LEN     = 300;
  localparam int QUIET_FROM   = 6000;
  localparam int QUIET_TO     = 14000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  slid_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  slid_pkg::rsp_t rsp;

  slid_pkg::cmd_t cmd_backlog[$];
  slid_pkg::rsp_t predicted_rsps[$];
  logic signed [slid_pkg::VAL_W-1:0] list_vals [slid_pkg::DEPTH];
  int list_cnt = 0;
  int shadow_cnt = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  int errors = 0;

  sorted_list_insert_delete_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Table model: updates the list for one command and returns its response.
  function automatic slid_pkg::rsp_t sorted_list_apply(slid_pkg::cmd_t c);
    slid_pkg::rsp_t r;
    int slot;
    int pos;
    r = '0;
    pos = -1;
    case (c.mode)
      slid_pkg::MODE_INSERT: begin
        if (list_cnt < slid_pkg::DEPTH) begin
          slot = list_cnt;
          for (int i = 0; i < list_cnt; i++) begin
            if ($signed(list_vals[i]) >= $signed(c.new_value)) begin
              slot = i;
              break;
            end
          end
          for (int i = list_cnt; i > slot; i--) list_vals[i] = list_vals[i-1];
          list_vals[slot] = c.new_value;
          list_cnt++;
          r.ok = 1'b1;
        end
      end
      slid_pkg::MODE_DELETE: if (int'(c.position) < list_cnt) pos = c.position;
      slid_pkg::MODE_POP:    if (list_cnt > 0) pos = 0;
      default: ;
    endcase
    if (pos >= 0) begin
      r.removed_value = list_vals[pos];
      for (int i = pos; i + 1 < list_cnt; i++) list_vals[i] = list_vals[i+1];
      list_cnt--;
      r.ok = 1'b1;
    end
    r.count_after = slid_pkg::OUT_CNT_W'(list_cnt);
    return r;
  endfunction

  function automatic bit idle_roll();
    if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 6;
  endfunction

  // Queue one command; the generator tracks the fill level to aim positions.
  task automatic add_cmd(logic [slid_pkg::MODE_W-1:0] m,
                         logic signed [slid_pkg::VAL_W-1:0] v, int p);
    slid_pkg::cmd_t c;
    c.mode      = m;
    c.new_value = v;
    c.position  = slid_pkg::POS_W'(p);
    cmd_backlog.push_back(c);
    case (m)
      slid_pkg::MODE_INSERT: if (shadow_cnt < slid_pkg::DEPTH) shadow_cnt++;
      slid_pkg::MODE_DELETE: if (p < shadow_cnt) shadow_cnt--;
      slid_pkg::MODE_POP:    if (shadow_cnt > 0) shadow_cnt--;
      default: ;
    endcase
  endtask

  function automatic logic signed [slid_pkg::VAL_W-1:0] rand_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel < 8) return $signed($urandom_range(0, 8)) - 4;
    if (sel == 8) return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom_range(0, 1) ? 32'sh7fff_fff0 + $urandom_range(0, 15)
                                : 32'sh8000_0000 + $urandom_range(0, 15);
  endfunction

  initial begin
    int regime;
    int roll;
    int p;
    logic [slid_pkg::MODE_W-1:0] m;

    // Empty table, then extremes, out-of-range deletes, fill to full.
    add_cmd(slid_pkg::MODE_POP, 0, 0);
    add_cmd(slid_pkg::MODE_DELETE, 0, 0);
    add_cmd(MODE_UNUSED, 32'sh1234_5678, 3);
    add_cmd(slid_pkg::MODE_INSERT, 0, 0);
    add_cmd(slid_pkg::MODE_INSERT, 32'sh7fff_ffff, 0);
    add_cmd(slid_pkg::MODE_INSERT, 32'sh8000_0000, 15);
    add_cmd(slid_pkg::MODE_INSERT, -1, 0);
    add_cmd(slid_pkg::MODE_INSERT, 0, 0);
    add_cmd(slid_pkg::MODE_DELETE, 0, 5);
    add_cmd(slid_pkg::MODE_DELETE, 0, 15);
    add_cmd(slid_pkg::MODE_DELETE, 0, 4);
    add_cmd(slid_pkg::MODE_POP, 0, 0);
    for (int i = 0; i < 13; i++) begin
      add_cmd(slid_pkg::MODE_INSERT,
              (i % 4 == 0) ? 32'sh8000_0000 : (i % 4 == 1) ? 32'sh7fff_ffff
              : rand_value(), $urandom_range(0, 15));
    end
    add_cmd(slid_pkg::MODE_INSERT, 7, 0);
    add_cmd(slid_pkg::MODE_DELETE, 0, 15);

    regime = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) regime = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll == 0) m = MODE_UNUSED;
      else if (roll < (regime == 0 ? 70 : regime == 1 ? 25 : 45)) m = slid_pkg::MODE_INSERT;
      else if (roll < (regime == 0 ? 85 : regime == 1 ? 65 : 75)) m = slid_pkg::MODE_DELETE;
      else m = slid_pkg::MODE_POP;
      if (shadow_cnt > 0 && $urandom_range(0, 9) < 7) p = $urandom_range(0, shadow_cnt - 1);
      else p = $urandom_range(0, 15);
      add_cmd(m, rand_value(), p);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || predicted_rsps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sorted_list_insert_delete_top");
    end else begin
      $display("FAIL sorted_list_insert_delete_top");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL sorted_list_insert_delete_top");
      $finish;
    end
  end

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) predicted_rsps.push_back(sorted_list_apply(cmd));
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() != 0 && !idle_roll()) begin
          cmd       <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Response stall, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (cycle_cnt == HOLD_START) hold_left <= HOLD_LEN;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      rsp_stall <= (cycle_cnt == HOLD_START) || (hold_left > 1) || idle_roll();
    end
  end

  // Response monitor
  always @(posedge clk) begin
    slid_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (predicted_rsps.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction ok=%0b count=%0d removed=%0d",
                 $time, rsp.ok, rsp.count_after, rsp.removed_value);
      end else begin
        want = predicted_rsps.pop_front();
        if (rsp.ok !== want.ok) begin
          errors++;
          $display("%0t: ok mismatch exp=%0b act=%0b", $time, want.ok, rsp.ok);
        end
        if (rsp.count_after !== want.count_after) begin
          errors++;
          $display("%0t: count_after mismatch exp=%0d act=%0d",
                   $time, want.count_after, rsp.count_after);
        end
        if (rsp.removed_value !== want.removed_value) begin
          errors++;
          $display("%0t: removed_value mismatch exp=%0d act=%0d",
                   $time, want.removed_value, rsp.removed_value);
        end
      end
    end
  end

endmodule
